// ----- sv/bpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the button press classifier
// Beat payloads, config register indexes, button and action codes, phases.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // One sample beat: button levels for one tick, 1 = pressed
  typedef struct packed {
    logic team1_pressed;
    logic team2_pressed;
    logic undo_pressed;
  } bpc_in_t;

  // One result beat
  typedef struct packed {
    logic [2:0] action_code;
    logic [7:0] sequence_res;
    logic       entering_sleep;
  } bpc_out_t;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] lockout_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] idle_ticks;
  } bpc_cfg_t;

  // Status from the classifier to the top level
  typedef struct packed {
    logic asleep;
  } bpc_status_t;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_LOCKOUT_TICKS    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_TICKS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_IDLE_TICKS       = 2'd2;

  localparam logic [15:0] LOCKOUT_TICKS_RST    = 16'd50;
  localparam logic [15:0] LONG_PRESS_TICKS_RST = 16'd3000;
  localparam logic [15:0] IDLE_TICKS_RST       = 16'd3000;

  // Button being timed
  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_TEAM1 = 2'd1;
  localparam logic [1:0] BTN_TEAM2 = 2'd2;
  localparam logic [1:0] BTN_UNDO  = 2'd3;

  // Action codes
  localparam logic [2:0] ACT_SLEEP       = 3'd0;
  localparam logic [2:0] ACT_SHORT_TEAM1 = 3'd1;
  localparam logic [2:0] ACT_SHORT_TEAM2 = 3'd2;
  localparam logic [2:0] ACT_SHORT_UNDO  = 3'd3;
  localparam logic [2:0] ACT_LONG_UNDO   = 3'd4;
  localparam logic [2:0] ACT_LONG_TEAM1  = 3'd5;
  localparam logic [2:0] ACT_LONG_TEAM2  = 3'd6;

  localparam logic [7:0] SEQ_FIRST = 8'd1;
  localparam logic [7:0] SEQ_LAST  = 8'd255;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HOLD  = 4'b0010,
    PH_WAIT  = 4'b0100,
    PH_SLEEP = 4'b1000
  } bpc_phase_e;

endpackage

// ----- sv/button_press_classifier_core.sv -----
`timescale 1ns / 1ps
// A sample beat accepted into the input register is classified combinationally, which loads
// its result (if any) into the result register, from which that beat can be taken.
// Throughput: one sample beat per cycle unless stalled, the tick update being combinational;
// input is taken while a result waits and stalls only once both registers are full.
// Reset: rst_ni async, active low; config returns to 50/3000/3000 ticks,
// classifier to idle with lockout elapsed and sequence number 1.
// ----------------------------------------------------------------------------
// button_press_classifier_core: short/long press classifier for three buttons
// Input register -> one-tick classifier update -> result register.
// ----------------------------------------------------------------------------
module button_press_classifier_core
  import bpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // sample beats, one per tick
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpc_in_t             in_data_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpc_out_t            out_data_o
);

  bpc_cfg_t    cfg;
  bpc_status_t status;
  logic        res_valid;
  bpc_out_t    res;

  // input register
  logic     s1_valid_q, s1_valid_d;
  bpc_in_t  s1_data_q;
  // result register
  logic     out_valid_q, out_valid_d;
  bpc_out_t out_data_q;

  logic out_free;  // result register is empty or being drained this cycle
  logic s1_fire;   // sample in the input register is processed this cycle
  logic in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  bpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The whole tick update is combinational off the input register; state
  // only advances when the result register can take whatever the tick gives.
  bpc_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_fire),
    .sample_i    (s1_data_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire)      s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;
  end

  // A tick with no result empties the result register (old beat was drained
  // or absent, since s1_fire implies out_free).
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire)          out_valid_d = res_valid;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (s1_fire && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // sleep beat carries no code and no sequence number
  a_sleep_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entering_sleep |->
      out_data_o.action_code == ACT_SLEEP && out_data_o.sequence_res == 8'd0)
    else $error("sleep beat with nonzero code or sequence");

  // an action beat always has a nonzero sequence number and a real code
  a_action_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.entering_sleep |->
      out_data_o.sequence_res != 8'd0 && out_data_o.action_code != ACT_SLEEP)
    else $error("action beat with zero sequence or zero code");

  // sleep is sticky until reset
  a_sleep_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.asleep |=> status.asleep)
    else $error("left sleep without reset");

  // nothing is produced once asleep
  a_sleep_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.asleep && s1_fire |-> !res_valid)
    else $error("result produced while asleep");

  // entering sleep only from a sleep event beat
  a_sleep_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.asleep) |-> $past(s1_fire && res_valid && res.entering_sleep))
    else $error("sleep entered without sleep event");
`endif

endmodule

// ----- sv/bpc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_cfg_regs: configuration register file
// Three 16-bit timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bpc_cfg_regs
  import bpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output bpc_cfg_t            cfg_o
);

  bpc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOCKOUT_TICKS:    cfg_d.lockout_ticks    = cfg_wdata_i;
        REG_LONG_PRESS_TICKS: cfg_d.long_press_ticks = cfg_wdata_i;
        REG_IDLE_TICKS:       cfg_d.idle_ticks       = cfg_wdata_i;
        default:              cfg_d = cfg_q;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lockout_ticks    <= LOCKOUT_TICKS_RST;
      cfg_q.long_press_ticks <= LONG_PRESS_TICKS_RST;
      cfg_q.idle_ticks       <= IDLE_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/bpc_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_fsm: press classifier state and one-tick update
// Phase machine, hold/lockout/idle timers and sequence counter.
// ----------------------------------------------------------------------------
module bpc_fsm
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,      // one tick sample is processed
  input  bpc_in_t     sample_i,
  input  bpc_cfg_t    cfg_i,
  output logic        res_valid_o,
  output bpc_out_t    res_o,
  output bpc_status_t status_o
);

  bpc_phase_e phase_q, phase_d;
  logic [1:0]  held_q, held_d;
  logic [15:0] hold_tmr_q, hold_tmr_d;
  logic [15:0] lock_tmr_q, lock_tmr_d;
  logic [15:0] idle_tmr_q, idle_tmr_d;
  logic [7:0]  seq_q, seq_d;

  logic        held_lvl;
  logic [1:0]  sel_btn;
  logic [15:0] hold_inc;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] seq_next(input logic [7:0] v);
    return (v == SEQ_LAST) ? SEQ_FIRST : v + 8'd1;
  endfunction

  // level of the button currently being timed
  always_comb begin
    case (held_q)
      BTN_TEAM1: held_lvl = sample_i.team1_pressed;
      BTN_TEAM2: held_lvl = sample_i.team2_pressed;
      default:   held_lvl = sample_i.undo_pressed;
    endcase
  end

  // fixed priority: team1, team2, undo
  always_comb begin
    if (sample_i.team1_pressed)      sel_btn = BTN_TEAM1;
    else if (sample_i.team2_pressed) sel_btn = BTN_TEAM2;
    else if (sample_i.undo_pressed)  sel_btn = BTN_UNDO;
    else                             sel_btn = BTN_NONE;
  end

  assign hold_inc = sat_inc(hold_tmr_q);

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    hold_tmr_d  = hold_tmr_q;
    lock_tmr_d  = lock_tmr_q;
    idle_tmr_d  = idle_tmr_q;
    seq_d       = seq_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (idle_tmr_q >= cfg_i.idle_ticks) begin
            phase_d              = PH_SLEEP;
            res_valid_o          = 1'b1;
            res_o.action_code    = ACT_SLEEP;
            res_o.sequence_res   = '0;
            res_o.entering_sleep = 1'b1;
          end else if (sel_btn != BTN_NONE && lock_tmr_q >= cfg_i.lockout_ticks) begin
            phase_d    = PH_HOLD;
            held_d     = sel_btn;
            hold_tmr_d = '0;
          end else begin
            idle_tmr_d = sat_inc(idle_tmr_q);
            lock_tmr_d = sat_inc(lock_tmr_q);
          end
        end
        PH_HOLD: begin
          if (!held_lvl) begin
            // short press: back to idle, timers restart
            res_valid_o        = 1'b1;
            res_o.sequence_res = seq_q;
            case (held_q)
              BTN_TEAM1: res_o.action_code = ACT_SHORT_TEAM1;
              BTN_TEAM2: res_o.action_code = ACT_SHORT_TEAM2;
              default:   res_o.action_code = ACT_SHORT_UNDO;
            endcase
            seq_d      = seq_next(seq_q);
            phase_d    = PH_IDLE;
            held_d     = BTN_NONE;
            hold_tmr_d = '0;
            lock_tmr_d = '0;
            idle_tmr_d = '0;
          end else begin
            hold_tmr_d = hold_inc;
            if (hold_inc >= cfg_i.long_press_ticks) begin
              res_valid_o        = 1'b1;
              res_o.sequence_res = seq_q;
              case (held_q)
                BTN_TEAM1: res_o.action_code = ACT_LONG_TEAM1;
                BTN_TEAM2: res_o.action_code = ACT_LONG_TEAM2;
                default:   res_o.action_code = ACT_LONG_UNDO;
              endcase
              seq_d   = seq_next(seq_q);
              phase_d = PH_WAIT;
            end
          end
        end
        PH_WAIT: begin
          if (!held_lvl) begin
            phase_d    = PH_IDLE;
            held_d     = BTN_NONE;
            hold_tmr_d = '0;
            lock_tmr_d = '0;
            idle_tmr_d = '0;
          end
        end
        PH_SLEEP: begin
          phase_d = PH_SLEEP;  // stays until reset
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      held_q     <= BTN_NONE;
      hold_tmr_q <= '0;
      lock_tmr_q <= 16'hFFFF;
      idle_tmr_q <= '0;
      seq_q      <= SEQ_FIRST;
    end else begin
      phase_q    <= phase_d;
      held_q     <= held_d;
      hold_tmr_q <= hold_tmr_d;
      lock_tmr_q <= lock_tmr_d;
      idle_tmr_q <= idle_tmr_d;
      seq_q      <= seq_d;
    end
  end

  assign status_o.asleep = (phase_q == PH_SLEEP);

endmodule
